/* rtl/assert_macros.svh */
// Assertion helpers included by the top-level module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define RRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define RRB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/rrb_pkg.sv */
package rrb_pkg;

  // Ring geometry
  localparam int unsigned Depth = 16384;
  localparam int unsigned PtrW  = $clog2(Depth);

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned FillW = 14;
  localparam int unsigned ThrW  = 15;
  localparam int unsigned CmpW  = (PtrW > ThrW) ? PtrW : ThrW;

  // Threshold reset values
  localparam logic [ThrW-1:0] StopReset   = ThrW'(12288);
  localparam logic [ThrW-1:0] ResumeReset = ThrW'(4096);

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_STOP   = 1'b0,
    CFG_RESUME = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic             pop_valid;
    logic [ByteW-1:0] pop_byte;
    logic             overwrote;
    logic             sender_allowed;
    logic [FillW-1:0] fill_level;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic push;
    logic pop;
  } ctl_cmd_t;

  // Pointer advance with wrap
  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrW'(Depth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

endpackage

/* rtl/rrb_ctrl.sv */
module rrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rrb_pkg::cmd_e     in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrb_pkg::ctl_cmd_t cmd_o
);

  rrb_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Take a beat when idle and the result slot is free or being drained
  assign in_ready_o  = (state_q == rrb_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      rrb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == rrb_pkg::CMD_POP) begin
            cmd_o.pop   = 1'b1;
            out_valid_d = 1'b0;
            state_d     = rrb_pkg::ST_READ;
          end else begin
            cmd_o.push  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      rrb_pkg::ST_READ: begin
        // memory read data is registered now
        out_valid_d = 1'b1;
        state_d     = rrb_pkg::ST_IDLE;
      end
      default: begin
        state_d = rrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rrb_datapath.sv */
module rrb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrb_pkg::ctl_cmd_t             cmd_i,
  input  logic [rrb_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                          cfg_we_i,
  input  rrb_pkg::cfg_reg_e             cfg_index_i,
  input  logic [rrb_pkg::ThrW-1:0]      cfg_data_i,
  output rrb_pkg::out_t                 out_data_o
);

  logic [rrb_pkg::ByteW-1:0] mem_q [rrb_pkg::Depth];
  logic [rrb_pkg::ByteW-1:0] rd_q;

  logic [rrb_pkg::PtrW-1:0]  rptr_q, rptr_d, wptr_q, wptr_d, wnext;
  logic [rrb_pkg::PtrW-1:0]  count_q, count_d;
  logic                      flow_q, flow_d;
  logic [rrb_pkg::ThrW-1:0]  stop_q, resume_q;
  rrb_pkg::out_t             res_q, res_d;
  logic                      nonempty;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q   <= rrb_pkg::StopReset;
      resume_q <= rrb_pkg::ResumeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rrb_pkg::CFG_STOP:   stop_q   <= cfg_data_i;
        rrb_pkg::CFG_RESUME: resume_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pointer, count and flow update
  assign wnext    = rrb_pkg::next_ptr(wptr_q);
  assign nonempty = (rptr_q != wptr_q);

  always_comb begin
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    count_d = count_q;
    flow_d  = flow_q;
    res_d   = '0;
    if (cmd_i.push) begin
      wptr_d = wnext;
      if (wnext == rptr_q) begin
        // ring full: drop the oldest byte
        rptr_d          = rrb_pkg::next_ptr(rptr_q);
        res_d.overwrote = 1'b1;
      end else begin
        count_d = count_q + rrb_pkg::PtrW'(1);
      end
      if (flow_q && (rrb_pkg::CmpW'(count_d) > rrb_pkg::CmpW'(stop_q))) begin
        flow_d = 1'b0;
      end
    end else if (cmd_i.pop && nonempty) begin
      rptr_d          = rrb_pkg::next_ptr(rptr_q);
      count_d         = count_q - rrb_pkg::PtrW'(1);
      res_d.pop_valid = 1'b1;
      if (!flow_q && (rrb_pkg::CmpW'(count_d) < rrb_pkg::CmpW'(resume_q))) begin
        flow_d = 1'b1;
      end
    end
    res_d.sender_allowed = flow_d;
    res_d.fill_level     = rrb_pkg::FillW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
      flow_q  <= 1'b1;
    end else begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      count_q <= count_d;
      flow_q  <= flow_d;
    end
  end

  // Result fields, captured at the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.pop) begin
      res_q <= res_d;
    end
  end

  // Byte store: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wptr_q] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      rd_q <= mem_q[rptr_q];
    end
  end

  // Byte only shown for a pop that found data
  always_comb begin
    out_data_o          = res_q;
    out_data_o.pop_byte = res_q.pop_valid ? rd_q : '0;
  end

endmodule

/* rtl/rx_ring_buffer_rts_flow_unit.sv */
// Receive byte ring buffer with RTS-style flow control.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per command,
// either a push of rx_byte or a pop of the oldest byte. Output channel
// (out_valid_o/out_ready_i/out_data_o): exactly one result beat per command,
// carrying the popped byte, an overwrite flag, the sender_allowed flag and the
// fill level after the command. A push into a full ring drops the oldest byte.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 is the stop threshold,
// index 1 the resume threshold; always ready, write only while idle.
// A push result is registered at acceptance; a pop result is registered after
// the READ state, which covers the registered read of the byte memory.
// Throughput: one push per cycle while results drain; no command is taken in READ.
// Reset clears pointers and count, asserts sender_allowed and loads the
// threshold defaults (12288 and 4096); memory contents are not cleared.
// If the receiver stalls, the result is held and a new command is taken only
// in the cycle in which the pending result is drained.
module rx_ring_buffer_rts_flow_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rrb_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rrb_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  rrb_pkg::cfg_reg_e         cfg_index_i,
  input  logic [rrb_pkg::ThrW-1:0]  cfg_data_i
);

  `include "assert_macros.svh"

  rrb_pkg::ctl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rrb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rx_byte_i   (in_data_i.rx_byte),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  `RRB_NEVER(a_no_accept_over_stall, in_ready_o && out_valid_o && !out_ready_i, "beat taken over stalled result")
  `RRB_ASSERT(a_push_result, in_valid_i && in_ready_o && (in_data_i.cmd == rrb_pkg::CMD_PUSH) |=> out_valid_o, "push result missing")
  `RRB_ASSERT(a_pop_busy, in_valid_i && in_ready_o && (in_data_i.cmd == rrb_pkg::CMD_POP) |=> !in_ready_o && !out_valid_o ##1 out_valid_o, "pop sequencing wrong")
  `RRB_NEVER(a_pop_no_drop, out_valid_o && out_data_o.pop_valid && out_data_o.overwrote, "pop flagged overwrite")

endmodule
